// ===== src/lse_pkg.sv =====
// shared types and constants for the lsb stego extractor
`default_nettype none

package lse_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned LEN_OUT_W = 32;

    // one recovered byte as it leaves the section sequencer
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              kind;
        logic              last;
    } res_t;

    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

endpackage : lse_pkg

`default_nettype wire

// ===== src/lse_fifo.sv =====
// small register queue with full and empty flags
`default_nettype none

module lse_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule : lse_fifo

`default_nettype wire

// ===== src/lse_bit_packer.sv =====
// front end: gathers two low bits per channel and packs them into bytes
`default_nettype none

module lse_bit_packer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pix_push,
    input  wire logic [lse_pkg::CHAN_W-1:0] red,
    input  wire logic [lse_pkg::CHAN_W-1:0] green,
    input  wire logic [lse_pkg::CHAN_W-1:0] blue,
    input  wire logic                       q_full,
    output logic                            byte_push,
    output logic [lse_pkg::BYTE_W-1:0]      byte_data
);

    import lse_pkg::*;

    // at most six bits wait between pixels, so twelve cover a new pixel
    logic [5:0]  buf_reg, buf_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [5:0]  six;
    logic [11:0] bits;
    logic [3:0]  sum;
    logic        accept;
    logic        has_byte;

    assign six      = {red[1:0], green[1:0], blue[1:0]};
    assign bits     = {buf_reg, six};
    assign sum      = cnt_reg + 4'd6;
    assign has_byte = (sum >= 4'd8);
    assign accept   = pix_push && !q_full;

    assign byte_push = accept && has_byte;

    // oldest eight pending bits, most significant first
    always_comb
    begin
        case (sum)
            4'd10:   byte_data = bits[9:2];
            4'd12:   byte_data = bits[11:4];
            default: byte_data = bits[7:0];
        endcase
    end

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            buf_next = six;
            cnt_next = has_byte ? sum - 4'd8 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule : lse_bit_packer

`default_nettype wire

// ===== src/lse_section_seq.sv =====
// back end: parses the length header and tags name and payload bytes
`default_nettype none

module lse_section_seq #(
    parameter int unsigned LENGTH_FIELD_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       byte_empty,
    input  wire logic [lse_pkg::BYTE_W-1:0] byte_data,
    output logic                            byte_pop,
    input  wire logic                       res_full,
    output logic                            res_push,
    output lse_pkg::res_t                   res_data,
    output logic [lse_pkg::LEN_OUT_W-1:0]   name_length,
    output logic [lse_pkg::LEN_OUT_W-1:0]   payload_size
);

    import lse_pkg::*;

    localparam int unsigned LFB       = LENGTH_FIELD_BITS;
    localparam int unsigned HDR_BYTES = LENGTH_FIELD_BITS / 8;
    localparam int unsigned IDX_W     = $clog2(2 * HDR_BYTES);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_NAME    = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LFB-1:0]     name_len_reg, name_len_next;
    logic [LFB-1:0]     size_reg, size_next;
    logic [LFB-1:0]     left_reg, left_next;
    logic [LFB+7:0]     name_shift;
    logic [LFB+7:0]     size_shift;
    logic               step;
    logic               left_is_one;

    assign step        = !byte_empty && !res_full;
    assign byte_pop    = step;
    assign name_shift  = {name_len_reg, byte_data};
    assign size_shift  = {size_reg, byte_data};
    assign left_is_one = (left_reg == LFB'(1));

    assign name_length  = LEN_OUT_W'(name_len_reg);
    assign payload_size = LEN_OUT_W'(size_reg);

    assign res_data.data = byte_data;
    assign res_data.kind = (phase_reg == PH_PAYLOAD) ? KIND_PAYLOAD : KIND_NAME;
    assign res_data.last = (phase_reg == PH_PAYLOAD) && left_is_one;
    assign res_push      = step && ((phase_reg == PH_NAME) || (phase_reg == PH_PAYLOAD));

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        name_len_next = name_len_reg;
        size_next     = size_reg;
        left_next     = left_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (idx_reg < IDX_W'(HDR_BYTES))
                    begin
                        name_len_next = name_shift[LFB-1:0];
                    end
                    else
                    begin
                        size_next = size_shift[LFB-1:0];
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(2 * HDR_BYTES - 1))
                    begin
                        idx_next = '0;
                        if (name_len_next == '0)
                        begin
                            left_next  = size_next;
                            phase_next = (size_next == '0) ? PH_DONE : PH_PAYLOAD;
                        end
                        else
                        begin
                            left_next  = name_len_next;
                            phase_next = PH_NAME;
                        end
                    end
                end
                PH_NAME:
                begin
                    left_next = left_reg - 1'b1;
                    if (left_is_one)
                    begin
                        left_next  = size_reg;
                        phase_next = (size_reg == '0) ? PH_DONE : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next = left_reg - 1'b1;
                    if (left_is_one)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    // drained bytes are dropped until reset
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            idx_reg      <= '0;
            name_len_reg <= '0;
            size_reg     <= '0;
            left_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            name_len_reg <= name_len_next;
            size_reg     <= size_next;
            left_reg     <= left_next;
        end
    end

endmodule : lse_section_seq

`default_nettype wire

// ===== src/lsb_stego_extractor.sv =====
// top level of the lsb stego extractor: bit packer, byte queue, section sequencer, result queue
`default_nettype none

// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------------
// pixel in  | push / full        | red, green, blue (bits 1:0 carry hidden data)
// result    | empty / pop        | out_byte, kind, last, name_length, payload_size
//
// one pixel transaction can be taken every cycle while full is low; each pixel yields at most one byte
// the packer makes a byte in the same cycle; the byte queue holds it until the sequencer pops it
// reset clears bit buffer, header counters and both queues; no clearing pass
// a full result queue stalls the sequencer, which fills the byte queue and then raises full
// header bytes and bytes after the final payload byte give no result transaction

module lsb_stego_extractor #(
    parameter int unsigned LENGTH_FIELD_BITS = 32,
    parameter int unsigned BYTE_Q_DEPTH      = 2,
    parameter int unsigned RES_Q_DEPTH       = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [lse_pkg::CHAN_W-1:0] red,
    input  wire logic [lse_pkg::CHAN_W-1:0] green,
    input  wire logic [lse_pkg::CHAN_W-1:0] blue,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [lse_pkg::BYTE_W-1:0]      out_byte,
    output logic                            kind,
    output logic                            last,
    output logic [lse_pkg::LEN_OUT_W-1:0]   name_length,
    output logic [lse_pkg::LEN_OUT_W-1:0]   payload_size
);

    import lse_pkg::*;

    // front to back byte queue
    logic              bq_push;
    logic [BYTE_W-1:0] bq_din;
    logic              bq_full;
    logic              bq_pop;
    logic [BYTE_W-1:0] bq_dout;
    logic              bq_empty;

    // back end to output queue
    logic              rq_push;
    res_t              rq_din;
    logic              rq_full;
    res_t              rq_dout;

    // the front stalls only when the byte queue has no room
    assign full = bq_full;

    lse_bit_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_push  (push),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .q_full    (bq_full),
        .byte_push (bq_push),
        .byte_data (bq_din)
    );

    lse_fifo #(
        .WIDTH (BYTE_W),
        .DEPTH (BYTE_Q_DEPTH)
    ) u_byte_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bq_push),
        .din   (bq_din),
        .full  (bq_full),
        .pop   (bq_pop),
        .dout  (bq_dout),
        .empty (bq_empty)
    );

    // name and size stay fixed once the header is in, so they bypass the result queue
    lse_section_seq #(
        .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_empty   (bq_empty),
        .byte_data    (bq_dout),
        .byte_pop     (bq_pop),
        .res_full     (rq_full),
        .res_push     (rq_push),
        .res_data     (rq_din),
        .name_length  (name_length),
        .payload_size (payload_size)
    );

    // result queue doubles as the output register
    lse_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_din),
        .full  (rq_full),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty)
    );

    assign out_byte = rq_dout.data;
    assign kind     = rq_dout.kind;
    assign last     = rq_dout.last;

endmodule : lsb_stego_extractor

`default_nettype wire
